// File: src/apr_pkg.sv
// shared widths and constants for the affine patch lift to rotation pipeline
// used by the divider and the top level; no dependencies
`default_nettype none
package apr_pkg;

    localparam int XW     = 24;  // axis component, signed q7.16
    localparam int SW     = 49;  // sum of squares
    localparam int AW     = 48;  // absolute determinant
    localparam int PW     = 50;  // factors s - 2|d| and s + 2|d|
    localparam int TW     = 51;  // divisor s + r
    localparam int QW     = 48;  // quotient of 2^65 / t
    localparam int ZW     = 24;  // scale, unsigned q8.16
    localparam int ROW_W  = 18;  // signed q1.16 row value
    localparam int CW     = 17;  // unsigned q1.16 magnitude
    localparam int SHW    = 5;   // normalising shift
    localparam int DIV_RW = TW + 1;

    localparam logic [ZW-1:0]     Z_MAX        = '1;
    localparam logic [CW-1:0]     ONE_Q16      = CW'(65536);
    localparam logic [TW-1:0]     T_MIN        = TW'(1) << 18;
    localparam logic [DIV_RW-1:0] DIV_REM_INIT = DIV_RW'(1) << 17;

endpackage
`default_nettype wire

// File: src/affine_patch_lift_to_rotation_top.sv
// top level of the affine patch lift: products, normalising, roots, division, rows
// depends on apr_pkg, apr_isqrt and apr_div
`default_nettype none
// Takes one patch (two axis vectors, signed q7.16) per clock while the output is
// not stalled and returns the lift scale z (unsigned q8.16) with the two rotation
// rows (q1.16). It accepts a new transfer every cycle unless frozen; the pipeline
// length is set by the bit-per-stage square roots (32, 24 and 17 stages) and the
// 48-stage divider. When a finished result is held at the output, the whole
// pipeline freezes and s_tready drops until the result is taken. A zero
// determinant returns z at its maximum and sets tuser.
module affine_patch_lift_to_rotation_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // x_axis_u, x_axis_v, y_axis_u, y_axis_v
    input  logic [95:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // scale_z, row0_a, row0_b, row0_c, row1_a, row1_b, row1_c, zero pad
    output logic [135:0] o_m_tdata,
    // degenerate
    output logic [0:0]   o_m_tuser
);
    import apr_pkg::*;

    typedef struct packed {
        logic signed [XW-1:0] xu;
        logic signed [XW-1:0] xv;
        logic signed [XW-1:0] yu;
        logic signed [XW-1:0] yv;
    } t_axes;

    typedef struct packed {
        t_axes ax;
        logic  degen;
        logic  dotpos;
    } t_mid;

    typedef struct packed {
        t_mid           mid;
        logic [SW-1:0]  s;
        logic [SHW-1:0] h;
    } t_rt_side;

    typedef struct packed {
        t_mid mid;
        logic tlow;
    } t_dv_side;

    typedef struct packed {
        logic [ZW-1:0]           z;
        logic signed [ROW_W-1:0] r0a;
        logic signed [ROW_W-1:0] r0b;
        logic signed [ROW_W-1:0] r1a;
        logic signed [ROW_W-1:0] r1b;
        logic                    degen;
    } t_row_side;

    localparam logic [34:0] ONE_SQ = 35'(1) << 32;

    function automatic logic [SHW-1:0] fit_shift(input logic [PW-1:0] v);
        logic [SHW-1:0] s;
        s = '0;
        for (int i = 32; i < PW; i++) begin
            if (v[i]) s = SHW'(i - 31);
        end
        return s;
    endfunction

    logic en;
    t_axes w_in;

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;
    assign w_in       = '{xu: i_s_tdata[23:0], xv: i_s_tdata[47:24],
                          yu: i_s_tdata[71:48], yv: i_s_tdata[95:72]};

    // stage a: products
    logic r_a_vld;
    t_axes r_a_ax;
    logic signed [47:0] r_a_xuu, r_a_xvv, r_a_yuu, r_a_yvv;
    logic signed [47:0] r_a_xuyv, r_a_xvyu, r_a_xuyu, r_a_xvyv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ax   <= w_in;
            r_a_xuu  <= w_in.xu * w_in.xu;
            r_a_xvv  <= w_in.xv * w_in.xv;
            r_a_yuu  <= w_in.yu * w_in.yu;
            r_a_yvv  <= w_in.yv * w_in.yv;
            r_a_xuyv <= w_in.xu * w_in.yv;
            r_a_xvyu <= w_in.xv * w_in.yu;
            r_a_xuyu <= w_in.xu * w_in.yu;
            r_a_xvyv <= w_in.xv * w_in.yv;
        end
    end

    // stage b: sum of squares, determinant, dot product
    logic signed [48:0] w_b_d, w_b_dot;
    logic [AW-1:0] w_b_ad;
    logic r_b_vld;
    t_mid r_b_mid;
    logic [SW-1:0] r_b_s;
    logic [AW-1:0] r_b_ad;

    always_comb begin
        w_b_d   = {r_a_xuyv[47], r_a_xuyv} - {r_a_xvyu[47], r_a_xvyu};
        w_b_dot = {r_a_xuyu[47], r_a_xuyu} + {r_a_xvyv[47], r_a_xvyv};
        w_b_ad  = w_b_d[48] ? AW'(-w_b_d) : w_b_d[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_mid.ax     <= r_a_ax;
            r_b_mid.degen  <= (w_b_d == '0);
            r_b_mid.dotpos <= !w_b_dot[48] && (w_b_dot != '0);
            r_b_ad         <= w_b_ad;
            r_b_s          <= {2'b00, r_a_xuu[46:0]} + {2'b00, r_a_xvv[46:0]}
                            + {2'b00, r_a_yuu[46:0]} + {2'b00, r_a_yvv[46:0]};
        end
    end

    // stage c: factors of s^2 - 4d^2
    logic r_c_vld;
    t_mid r_c_mid;
    logic [SW-1:0] r_c_s;
    logic [PW-1:0] r_c_p, r_c_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_mid <= r_b_mid;
            r_c_s   <= r_b_s;
            r_c_p   <= PW'(r_b_s) - {1'b0, r_b_ad, 1'b0};
            r_c_q   <= PW'(r_b_s) + {1'b0, r_b_ad, 1'b0};
        end
    end

    // stage d: shifts to bring each factor under 32 bits, total made even
    logic [SHW-1:0] w_d_sp, w_d_sq;
    logic r_d_vld;
    t_mid r_d_mid;
    logic [SW-1:0] r_d_s;
    logic [PW-1:0] r_d_p, r_d_q;
    logic [SHW-1:0] r_d_sp, r_d_sq;

    always_comb begin
        w_d_sp = fit_shift(r_c_p);
        w_d_sq = fit_shift(r_c_q);
        if (w_d_sp[0] ^ w_d_sq[0]) w_d_sp = w_d_sp + SHW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_mid <= r_c_mid;
            r_d_s   <= r_c_s;
            r_d_p   <= r_c_p;
            r_d_q   <= r_c_q;
            r_d_sp  <= w_d_sp;
            r_d_sq  <= w_d_sq;
        end
    end

    // stage e: apply shifts
    logic [SHW:0] w_e_sum;
    logic r_e_vld;
    t_mid r_e_mid;
    logic [SW-1:0] r_e_s;
    logic [31:0] r_e_pm, r_e_qm;
    logic [SHW-1:0] r_e_h;

    assign w_e_sum = {1'b0, r_d_sp} + {1'b0, r_d_sq};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_mid <= r_d_mid;
            r_e_s   <= r_d_s;
            r_e_pm  <= 32'(r_d_p >> r_d_sp);
            r_e_qm  <= 32'(r_d_q >> r_d_sq);
            r_e_h   <= w_e_sum[SHW:1];
        end
    end

    // stage f: product of the reduced factors
    logic r_f_vld;
    t_rt_side r_f_side;
    logic [63:0] r_f_prod;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side <= '{mid: r_e_mid, s: r_e_s, h: r_e_h};
            r_f_prod <= r_e_pm * r_e_qm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    logic rt_vld;
    logic [31:0] rt_root;
    t_rt_side rt_side;

    apr_isqrt #(.IN_W(64), .SIDE_W($bits(t_rt_side))) u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f_vld),
        .i_rad   (r_f_prod),
        .i_side  (r_f_side),
        .o_valid (rt_vld),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    // stage g: t = s + r
    logic [PW-1:0] w_g_r;
    logic [TW-1:0] w_g_t;
    logic r_g_vld;
    t_dv_side r_g_side;
    logic [TW-1:0] r_g_t;

    always_comb begin
        w_g_r = PW'(rt_root) << rt_side.h;
        w_g_t = TW'(rt_side.s) + TW'(w_g_r);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_t    <= w_g_t;
            r_g_side <= '{mid: rt_side.mid, tlow: (w_g_t < T_MIN)};
        end
    end

    logic dv_vld;
    logic [QW-1:0] dv_quo;
    t_dv_side dv_side;

    apr_div #(.SIDE_W($bits(t_dv_side))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_vld),
        .i_t     (r_g_t),
        .i_side  (r_g_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    logic zs_vld;
    logic [ZW-1:0] zs_root;
    t_dv_side zs_side;

    apr_isqrt #(.IN_W(QW), .SIDE_W($bits(t_dv_side))) u_sqrt_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_vld),
        .i_rad   (dv_quo),
        .i_side  (dv_side),
        .o_valid (zs_vld),
        .o_root  (zs_root),
        .o_side  (zs_side)
    );

    // stage h: final scale, component magnitudes
    logic signed [XW-1:0] w_h_ax [4];
    logic r_h_vld;
    logic [ZW-1:0] r_h_z;
    logic [XW-1:0] r_h_mag [4];
    logic r_h_neg [4];
    logic r_h_degen, r_h_dotpos;

    assign w_h_ax[0] = zs_side.mid.ax.xu;
    assign w_h_ax[1] = zs_side.mid.ax.xv;
    assign w_h_ax[2] = zs_side.mid.ax.yu;
    assign w_h_ax[3] = zs_side.mid.ax.yv;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_z      <= (zs_side.mid.degen || zs_side.tlow) ? Z_MAX : zs_root;
            r_h_degen  <= zs_side.mid.degen;
            r_h_dotpos <= zs_side.mid.dotpos;
            for (int i = 0; i < 4; i++) begin
                r_h_neg[i] <= w_h_ax[i][XW-1];
                r_h_mag[i] <= w_h_ax[i][XW-1] ? XW'(-w_h_ax[i]) : XW'(w_h_ax[i]);
            end
        end
    end

    // stage i: scale products
    logic r_i_vld;
    logic [ZW-1:0] r_i_z;
    logic [47:0] r_i_prod [4];
    logic r_i_neg [4];
    logic r_i_degen, r_i_dotpos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_z      <= r_h_z;
            r_i_degen  <= r_h_degen;
            r_i_dotpos <= r_h_dotpos;
            for (int i = 0; i < 4; i++) begin
                r_i_neg[i]  <= r_h_neg[i];
                r_i_prod[i] <= r_h_mag[i] * r_h_z;
            end
        end
    end

    // stage j: truncate, saturate to one, apply sign
    logic [CW-1:0] w_j_sat [4];
    logic r_j_vld;
    logic [ZW-1:0] r_j_z;
    logic signed [ROW_W-1:0] r_j_row [4];
    logic r_j_degen, r_j_dotpos;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_j_sat[i] = (r_i_prod[i][47:16] > 32'(ONE_Q16)) ? ONE_Q16 : r_i_prod[i][32:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_z      <= r_i_z;
            r_j_degen  <= r_i_degen;
            r_j_dotpos <= r_i_dotpos;
            for (int i = 0; i < 4; i++) begin
                r_j_row[i] <= r_i_neg[i] ? -$signed({1'b0, w_j_sat[i]})
                                         : $signed({1'b0, w_j_sat[i]});
            end
        end
    end

    // stage k: squares of the row values
    logic [35:0] w_k_sq [4];
    logic r_k_vld;
    logic [ZW-1:0] r_k_z;
    logic signed [ROW_W-1:0] r_k_row [4];
    logic [32:0] r_k_sq [4];
    logic r_k_degen, r_k_dotpos;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_k_sq[i] = 36'(r_j_row[i] * r_j_row[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_z      <= r_j_z;
            r_k_degen  <= r_j_degen;
            r_k_dotpos <= r_j_dotpos;
            for (int i = 0; i < 4; i++) begin
                r_k_row[i] <= r_j_row[i];
                r_k_sq[i]  <= w_k_sq[i][32:0];
            end
        end
    end

    // stage l: one minus the squared length, floored at zero
    logic [34:0] w_l_d0, w_l_d1;
    logic r_l_vld;
    t_row_side r_l_side;
    logic r_l_dotpos;
    logic [32:0] r_l_rad0, r_l_rad1;

    always_comb begin
        w_l_d0 = ONE_SQ - (35'(r_k_sq[0]) + 35'(r_k_sq[1]));
        w_l_d1 = ONE_SQ - (35'(r_k_sq[2]) + 35'(r_k_sq[3]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_side   <= '{z: r_k_z, r0a: r_k_row[0], r0b: r_k_row[1],
                            r1a: r_k_row[2], r1b: r_k_row[3], degen: r_k_degen};
            r_l_dotpos <= r_k_dotpos;
            r_l_rad0   <= w_l_d0[34] ? 33'd0 : w_l_d0[32:0];
            r_l_rad1   <= w_l_d1[34] ? 33'd0 : w_l_d1[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
            r_j_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_l_vld <= 1'b0;
        end else if (en) begin
            r_g_vld <= rt_vld;
            r_h_vld <= zs_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= r_i_vld;
            r_k_vld <= r_j_vld;
            r_l_vld <= r_k_vld;
        end
    end

    logic c0_vld, c1_vld;
    logic [CW-1:0] c0_root, c1_root;
    t_row_side c0_side;
    logic c1_dotpos;

    apr_isqrt #(.IN_W(33), .SIDE_W($bits(t_row_side))) u_sqrt_row0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_l_vld),
        .i_rad   (r_l_rad0),
        .i_side  (r_l_side),
        .o_valid (c0_vld),
        .o_root  (c0_root),
        .o_side  (c0_side)
    );

    apr_isqrt #(.IN_W(33), .SIDE_W(1)) u_sqrt_row1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_l_vld),
        .i_rad   (r_l_rad1),
        .i_side  (r_l_dotpos),
        .o_valid (c1_vld),
        .o_root  (c1_root),
        .o_side  (c1_dotpos)
    );

    // output register
    logic r_o_vld;
    t_row_side r_o_side;
    logic [CW-1:0] r_o_r0c;
    logic signed [ROW_W-1:0] r_o_r1c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= c0_vld && c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_side <= c0_side;
            r_o_r0c  <= c0_root;
            r_o_r1c  <= c1_dotpos ? -$signed({1'b0, c1_root}) : $signed({1'b0, c1_root});
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {5'b00000, r_o_r1c, r_o_side.r1b, r_o_side.r1a, r_o_r0c,
                         r_o_side.r0b, r_o_side.r0a, r_o_side.z};
    assign o_m_tuser  = r_o_side.degen;

`ifndef SYNTHESIS
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c0_vld == c1_vld)
        else $error("row root lanes out of step");
    a_degen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[23:0] == Z_MAX)
        else $error("zero determinant without saturated scale");
    a_third_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[76:60] <= ONE_Q16)
        else $error("row0 third component above one");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[41:24]) <= 18'sd65536
                        && $signed(o_m_tdata[41:24]) >= -18'sd65536))
        else $error("row0 first component out of range");
`endif

endmodule
`default_nettype wire

// File: src/apr_isqrt.sv
// pipelined integer square root, one result bit per stage, floor result
// sideband travels alongside; uses no package
`default_nettype none
module apr_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [IN_W-1:0]           i_rad,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [(IN_W+1)/2-1:0]     o_root,
    output logic [SIDE_W-1:0]         o_side
);
    localparam int PAIRS = (IN_W + 1) / 2;
    localparam int N     = 2 * PAIRS;
    localparam int RW    = PAIRS + 3;

    logic [N-1:0]      r_rad  [PAIRS];
    logic [RW-1:0]     r_rem  [PAIRS];
    logic [PAIRS-1:0]  r_root [PAIRS];
    logic              r_vld  [PAIRS];
    logic [SIDE_W-1:0] r_side [PAIRS];

    for (genvar k = 0; k < PAIRS; k++) begin : g_step
        logic [N-1:0]      w_rad;
        logic [RW-1:0]     w_rem;
        logic [PAIRS-1:0]  w_root;
        logic              w_vld;
        logic [SIDE_W-1:0] w_side;
        logic [RW-1:0]     w_cur;
        logic [RW-1:0]     w_trial;
        logic              w_ge;
        logic [RW-1:0]     n_rem;
        logic [PAIRS-1:0]  n_root;

        if (k == 0) begin : g_head
            assign w_rad  = N'(i_rad);
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_body
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            w_cur   = {w_rem[RW-3:0], w_rad[N-1-2*k -: 2]};
            w_trial = {1'b0, w_root, 2'b01};
            w_ge    = (w_cur >= w_trial);
            n_rem   = w_ge ? (w_cur - w_trial) : w_cur;
            n_root  = {w_root[PAIRS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= w_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[PAIRS-1];
    assign o_root  = r_root[PAIRS-1];
    assign o_side  = r_side[PAIRS-1];

endmodule
`default_nettype wire

// File: src/apr_div.sv
// pipelined restoring divider for 2^65 / t, one quotient bit per stage
// depends on apr_pkg for widths and the starting remainder
`default_nettype none
module apr_div #(
    parameter int SIDE_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [apr_pkg::TW-1:0] i_t,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output logic [apr_pkg::QW-1:0] o_quo,
    output logic [SIDE_W-1:0]      o_side
);
    import apr_pkg::*;

    logic [TW-1:0]     r_t    [QW];
    logic [DIV_RW-1:0] r_rem  [QW];
    logic [QW-1:0]     r_quo  [QW];
    logic              r_vld  [QW];
    logic [SIDE_W-1:0] r_side [QW];

    // dividend bits below the top are all zero, so each step only shifts in a zero
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [TW-1:0]     w_t;
        logic [DIV_RW-1:0] w_rem;
        logic [QW-1:0]     w_quo;
        logic              w_vld;
        logic [SIDE_W-1:0] w_side;
        logic [DIV_RW-1:0] w_cur;
        logic              w_ge;
        logic [DIV_RW-1:0] n_rem;

        if (k == 0) begin : g_head
            assign w_t    = i_t;
            assign w_rem  = DIV_REM_INIT;
            assign w_quo  = '0;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_body
            assign w_t    = r_t[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_vld  = r_vld[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            w_cur = {w_rem[DIV_RW-2:0], 1'b0};
            w_ge  = (w_cur >= {1'b0, w_t});
            n_rem = w_ge ? (w_cur - {1'b0, w_t}) : w_cur;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[k]    <= w_t;
                r_rem[k]  <= n_rem;
                r_quo[k]  <= {w_quo[QW-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
`default_nettype wire

// File: test/apr_checker.sv
// result checker for the affine patch lift: predicts each output transfer from
// the accepted input transfers and compares field by field; uses apr_pkg widths
module apr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [95:0]  i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,
    input  logic [0:0]   i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    import apr_pkg::*;

    typedef struct packed {
        logic [0:0]       degen;
        logic [ROW_W-1:0] r1c;
        logic [ROW_W-1:0] r1b;
        logic [ROW_W-1:0] r1a;
        logic [CW-1:0]    r0c;
        logic [ROW_W-1:0] r0b;
        logic [ROW_W-1:0] r0a;
        logic [ZW-1:0]    z;
    } t_lift;

    t_lift lift_q[$];

    assign o_pending = lift_q.size();

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int fit_shift(input logic [63:0] v);
        int s;
        s = 0;
        while ((v >> s) >= 64'h1_0000_0000) s++;
        return s;
    endfunction

    function automatic longint row_val(input longint a, input logic [63:0] zq);
        logic [63:0] m, p;
        m = (a < 0) ? -a : a;
        p = (m * zq) >> 16;
        if (p > 65536) p = 65536;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] tilt(input longint a, input longint b);
        logic [63:0] s;
        s = a * a + b * b;
        if (s >= 64'h1_0000_0000) return 0;
        return root64(64'h1_0000_0000 - s);
    endfunction

    function automatic t_lift lift_patch(input logic [95:0] d);
        longint xu, xv, yu, yv, det, r0a, r0b, r1a, r1b, r1c;
        logic [63:0] s, ad, p, q, r, t, quo, zq, big;
        int sp, sq;
        t_lift e;
        xu = longint'($signed(d[23:0]));
        xv = longint'($signed(d[47:24]));
        yu = longint'($signed(d[71:48]));
        yv = longint'($signed(d[95:72]));
        s = xu * xu + xv * xv + yu * yu + yv * yv;
        det = xu * yv - xv * yu;
        ad = (det < 0) ? -det : det;
        if (ad == 0) begin
            zq = Z_MAX;
        end else begin
            p = s - 2 * ad;
            q = s + 2 * ad;
            sp = fit_shift(p);
            sq = fit_shift(q);
            if ((sp + sq) % 2 != 0) sp++;
            r = root64((p >> sp) * (q >> sq)) << ((sp + sq) / 2);
            t = s + r;
            if (t < 64'd262144) begin
                zq = Z_MAX;
            end else begin
                big = 64'd1 << 63;
                quo = 4 * (big / t) + (4 * (big % t)) / t;
                zq = root64(quo);
                if (zq > Z_MAX) zq = Z_MAX;
            end
        end
        r0a = row_val(xu, zq);
        r0b = row_val(xv, zq);
        r1a = row_val(yu, zq);
        r1b = row_val(yv, zq);
        r1c = longint'(tilt(r1a, r1b));
        if (xu * yu + xv * yv > 0) r1c = -r1c;
        e.z = zq[ZW-1:0];
        e.r0a = r0a[ROW_W-1:0];
        e.r0b = r0b[ROW_W-1:0];
        e.r0c = tilt(r0a, r0b);
        e.r1a = r1a[ROW_W-1:0];
        e.r1b = r1b[ROW_W-1:0];
        e.r1c = r1c[ROW_W-1:0];
        e.degen = (ad == 0);
        return e;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("lift error: %s got %0h want %0h", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_lift e, g;
        if (!i_rst_n) begin
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) lift_q.push_back(lift_patch(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                g = {i_m_tuser, i_m_tdata[130:0]};
                if (lift_q.size() == 0) begin
                    report("unexpected transfer", 0, 0);
                end else begin
                    e = lift_q.pop_front();
                    if (g.z != e.z) report("scale_z", g.z, e.z);
                    if (g.r0a != e.r0a) report("row0_a", g.r0a, e.r0a);
                    if (g.r0b != e.r0b) report("row0_b", g.r0b, e.r0b);
                    if (g.r0c != e.r0c) report("row0_c", g.r0c, e.r0c);
                    if (g.r1a != e.r1a) report("row1_a", g.r1a, e.r1a);
                    if (g.r1b != e.r1b) report("row1_b", g.r1b, e.r1b);
                    if (g.r1c != e.r1c) report("row1_c", g.r1c, e.r1c);
                    if (g.degen != e.degen) report("degenerate", g.degen, e.degen);
                end
            end
        end
    end
endmodule

// File: test/tb.sv
// testbench top for affine_patch_lift_to_rotation_top: drives patches with random
// gaps and output stalls; apr_checker predicts and compares
module tb;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [135:0] m_tdata;
    logic [0:0]   m_tuser;
    int           fail_count, pending;
    int           send_idle = 33, recv_idle = 51;
    bit           hold_off = 0;
    int           quiet = 0;

    always #6 i_clk = ~i_clk;

    affine_patch_lift_to_rotation_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    apr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("affine_patch_lift_to_rotation_top: mismatch");
            $finish;
        end
    end

    function automatic logic [23:0] pick_comp();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'($signed($urandom_range(131072)) - 65536);
            3: return 24'($signed($urandom_range(2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_patch(input logic [95:0] d);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        logic [23:0] a, b, k;
        repeat (n) begin
            a = pick_comp();
            b = pick_comp();
            k = 24'($urandom_range(3));
            // a tenth are collinear axes, mostly giving a zero determinant
            if ($urandom_range(9) == 0)
                send_patch({24'($signed(b) * $signed(k)), 24'($signed(a) * $signed(k)), b, a});
            else
                send_patch({pick_comp(), pick_comp(), b, a});
        end
    endtask

    // always waits for a clock edge before testing pending, so the last transfer is counted
    task automatic drain();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, zero determinant, tiny determinant, sign cases
        send_patch('0);
        send_patch({24'h800000, 24'h800000, 24'h800000, 24'h800000});
        send_patch({24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff});
        send_patch({24'h7fffff, 24'h0, 24'h0, 24'h7fffff});
        send_patch({24'h800000, 24'h0, 24'h0, 24'h800000});
        send_patch({24'h010000, 24'h0, 24'h0, 24'h010000});
        send_patch({24'h0, 24'h010000, 24'h010000, 24'h0});
        send_patch({24'h010000, 24'h008000, 24'h0, 24'h010000});
        send_patch({24'h010000, 24'hff8000, 24'h0, 24'h010000});
        send_patch({24'h000001, 24'h0, 24'h0, 24'h000001});
        send_patch({24'h000001, 24'h000001, 24'h0, 24'h000002});
        send_patch({24'h7fffff, 24'h7ffffe, 24'h7ffffe, 24'h7ffffd});
        send_patch({24'h555555, 24'haaaaaa, 24'hffffff, 24'h000001});
        send_patch({24'haaaaaa, 24'h555555, 24'h123456, 24'hedcba9});
        send_patch({24'h00c000, 24'h004000, 24'hff0000, 24'h008000});
        send_random(500);
        // long output stall while the input keeps offering
        hold_off <= 1;
        fork
            begin repeat (400) @(posedge i_clk); hold_off <= 0; end
            begin send_idle = 0; send_random(200); s_tvalid <= 0; end
        join
        drain();
        send_idle = 51;
        recv_idle = 33;
        send_random(400);
        send_idle = 0;
        recv_idle = 0;
        send_random(350);
        s_tvalid <= 0;
        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("affine_patch_lift_to_rotation_top: match");
        else
            $display("affine_patch_lift_to_rotation_top: mismatch");
        $finish;
    end
endmodule

// File: affine_patch_lift_to_rotation_top.f
src/apr_pkg.sv
src/apr_isqrt.sv
src/apr_div.sv
src/affine_patch_lift_to_rotation_top.sv
test/apr_checker.sv
test/tb.sv
